FILE: src/ssf_pkg.sv
// Shared types and constants of the shortest-seek-first scheduler.
// Used by every module in src; depends on nothing.
package ssf_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int ID_WIDTH        = 8;
   localparam int TRACK_WIDTH     = 16;
   localparam int LEVEL_WIDTH     = 6;
   localparam int DIST_WIDTH      = TRACK_WIDTH + 1;
   localparam int REQ_DATA_WIDTH  = 24;
   localparam int RSP_DATA_WIDTH  = 48;

   localparam logic [DIST_WIDTH-1:0] DIST_NONE = {1'b1, {TRACK_WIDTH{1'b0}}};

   typedef enum logic {
      FUNC_ADD   = 1'b0,
      FUNC_FETCH = 1'b1
   } ssf_func_type;

   typedef enum logic [1:0] {
      STATUS_QUEUED = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_SERVED = 2'd2,
      STATUS_EMPTY  = 2'd3
   } ssf_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIMPLE,
      ST_SCAN,
      ST_SHIFT,
      ST_REPLY
   } ssf_state_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]    id;
      logic [TRACK_WIDTH-1:0] track;
   } ssf_entry_type;

   typedef struct packed {
      logic clear;
      logic sample;
   } ssf_seek_ctrl_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]    id;
      logic [TRACK_WIDTH-1:0] track;
      logic [DIST_WIDTH-1:0]  span;
   } ssf_seek_best_type;

endpackage

FILE: src/ssf_queue_ram.sv
// Request queue storage: one write port, one read port with registered data.
// Depends on ssf_pkg.
module ssf_queue_ram #(
   parameter int DEPTH = ssf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  ssf_pkg::ssf_entry_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output ssf_pkg::ssf_entry_type        rd_data
);
   import ssf_pkg::*;

   ssf_entry_type mem_ff [DEPTH];
   ssf_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ssf_seek_unit.sv
// Shared distance and compare unit: one entry per cycle, keeps the nearest.
// Strict less-than keeps the oldest on ties. Depends on ssf_pkg.
module ssf_seek_unit #(
   parameter int ADDR_WIDTH = $clog2(ssf_pkg::QUEUE_DEPTH_DEF)
) (
   input  logic                               clock,
   input  ssf_pkg::ssf_seek_ctrl_type         ctrl,
   input  logic [ADDR_WIDTH-1:0]              idx,
   input  ssf_pkg::ssf_entry_type             entry,
   input  logic [ssf_pkg::TRACK_WIDTH-1:0]    head,
   output logic [ADDR_WIDTH-1:0]              best_idx,
   output ssf_pkg::ssf_seek_best_type         best
);
   import ssf_pkg::*;

   logic [TRACK_WIDTH-1:0] span;
   logic                   closer;
   logic [ADDR_WIDTH-1:0]  best_idx_ff;
   ssf_seek_best_type      best_ff;

   assign span   = (entry.track >= head) ? (entry.track - head) : (head - entry.track);
   assign closer = {1'b0, span} < best_ff.span;

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         best_ff.span <= DIST_NONE;
      end else if (ctrl.sample && closer) begin
         best_ff.span  <= {1'b0, span};
         best_ff.id    <= entry.id;
         best_ff.track <= entry.track;
         best_idx_ff   <= idx;
      end
   end

   assign best_idx = best_idx_ff;
   assign best     = best_ff;

endmodule

FILE: src/shortest_seek_first_scheduler.sv
// Shortest-seek-first disk request scheduler. Requests sit oldest first in a queue memory
// with one write port and one read port. An add is answered from ST_SIMPLE once the output
// register is free. A fetch over n pending requests scans them through one distance
// comparator, one memory read per cycle, then closes the gap by moving each later entry
// up one place, one per cycle. The memory's single read port sets the length of a
// fetch. Ready is high only between items, so the next item can be taken in the cycle
// after a result is loaded; a finished result waits in the output register while the
// next item is taken, and a result still held there delays loading the next one by the
// cycles it waits.
// Depends on ssf_pkg, ssf_queue_ram and ssf_seek_unit.
module shortest_seek_first_scheduler #(
   parameter int QUEUE_DEPTH = ssf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // request_id [7:0], track_number [23:8]
   input  logic [ssf_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // func [0]
   input  logic [0:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // served_id [7:0], served_track [23:8], seek_distance [39:24], queue_level [45:40]
   output logic [ssf_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // status [1:0]
   output logic [1:0]                           rsp_tuser
);
   import ssf_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

   ssf_state_type          state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   inflight_ff, inflight_in;
   logic [AW-1:0]          inflight_idx_ff, inflight_idx_in;
   ssf_func_type           func_ff;
   logic [ID_WIDTH-1:0]    id_ff;
   logic [TRACK_WIDTH-1:0] head_ff;

   logic                   req_fire;
   logic                   out_free;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   ssf_entry_type          ram_wdata;
   ssf_entry_type          ram_rdata;

   ssf_seek_ctrl_type      seek_ctrl;
   logic [AW-1:0]          best_idx;
   ssf_seek_best_type      best;

   logic                   rsp_valid_ff;
   logic                   rsp_load;
   ssf_status_type         rsp_status_ff, rsp_status_in;
   logic [ID_WIDTH-1:0]    rsp_id_ff, rsp_id_in;
   logic [TRACK_WIDTH-1:0] rsp_track_ff, rsp_track_in;
   logic [TRACK_WIDTH-1:0] rsp_dist_ff, rsp_dist_in;
   logic [LEVEL_WIDTH-1:0] rsp_level_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   ssf_queue_ram #(
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(rd_idx_ff[AW-1:0]),
      .rd_data(ram_rdata)
   );

   ssf_seek_unit #(
      .ADDR_WIDTH(AW)
   ) u_seek (
      .clock   (clock),
      .ctrl    (seek_ctrl),
      .idx     (inflight_idx_ff),
      .entry   (ram_rdata),
      .head    (head_ff),
      .best_idx(best_idx),
      .best    (best)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         inflight_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         inflight_ff <= inflight_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff       <= rd_idx_in;
      inflight_idx_ff <= inflight_idx_in;
      if (req_fire) begin
         func_ff <= ssf_func_type'(req_tuser[0]);
         id_ff   <= req_tdata[7:0];
         head_ff <= req_tdata[23:8];
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_track_ff  <= rsp_track_in;
         rsp_dist_ff   <= rsp_dist_in;
         rsp_level_ff  <= LEVEL_WIDTH'(count_in);
      end
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      rd_idx_in       = rd_idx_ff;
      inflight_in     = 1'b0;
      inflight_idx_in = inflight_idx_ff;
      ram_we          = 1'b0;
      ram_waddr       = count_ff[AW-1:0];
      ram_wdata.id    = id_ff;
      ram_wdata.track = head_ff;
      seek_ctrl.clear = 1'b0;
      seek_ctrl.sample = 1'b0;
      rsp_load        = 1'b0;
      rsp_status_in   = STATUS_QUEUED;
      rsp_id_in       = '0;
      rsp_track_in    = '0;
      rsp_dist_in     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == FUNC_ADD || count_ff == '0) begin
                  state_in = ST_SIMPLE;
               end else begin
                  state_in        = ST_SCAN;
                  rd_idx_in       = '0;
                  seek_ctrl.clear = 1'b1;
               end
            end
         end
         ST_SIMPLE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (func_ff == FUNC_ADD) begin
                  if (count_ff == DEPTH_CNT) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end else begin
                  rsp_status_in = STATUS_EMPTY;
               end
            end
         end
         ST_SCAN: begin
            seek_ctrl.sample = inflight_ff;
            if (rd_idx_ff < count_ff) begin
               inflight_in     = 1'b1;
               inflight_idx_in = rd_idx_ff[AW-1:0];
               rd_idx_in       = rd_idx_ff + CW'(1);
            end else if (!inflight_ff) begin
               state_in  = ST_SHIFT;
               rd_idx_in = CW'(best_idx) + CW'(1);
            end
         end
         ST_SHIFT: begin
            ram_we    = inflight_ff;
            ram_waddr = inflight_idx_ff;
            ram_wdata = ram_rdata;
            if (rd_idx_ff < count_ff) begin
               inflight_in     = 1'b1;
               inflight_idx_in = AW'(rd_idx_ff - CW'(1));
               rd_idx_in       = rd_idx_ff + CW'(1);
            end else if (!inflight_ff) begin
               count_in = count_ff - CW'(1);
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = STATUS_SERVED;
               rsp_id_in     = best.id;
               rsp_track_in  = best.track;
               rsp_dist_in   = best.span[TRACK_WIDTH-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_level_ff, rsp_dist_ff, rsp_track_ff, rsp_id_ff};

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");

   a_scan_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && state_in == ST_SHIFT) |-> !best.span[TRACK_WIDTH])
      else $error("scan finished without a candidate");

   a_serve_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && state_in == ST_REPLY) |=>
         count_ff == $past(count_ff) - CW'(1))
      else $error("served item did not leave the queue");

   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_EMPTY) |-> rsp_level_ff == '0)
      else $error("empty status with nonzero level");

endmodule

FILE: test/shortest_seek_first_scheduler_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for shortest_seek_first_scheduler: streams add and fetch items,
// predicts each status item from a local copy of the request queue and compares.
// Depends on ssf_pkg and the RTL under src.
module shortest_seek_first_scheduler_tb;
   import ssf_pkg::*;

   localparam int QUEUE_DEPTH   = QUEUE_DEPTH_DEF;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int DRAIN_CYCLES  = 150;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      ssf_func_type           func;
      logic [ID_WIDTH-1:0]    id;
      logic [TRACK_WIDTH-1:0] track;
   } disk_item_type;

   typedef struct packed {
      ssf_status_type         status;
      logic [ID_WIDTH-1:0]    id;
      logic [TRACK_WIDTH-1:0] track;
      logic [TRACK_WIDTH-1:0] span;
      logic [LEVEL_WIDTH-1:0] level;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   disk_item_type      request_backlog[$];
   disk_item_type      on_bus;
   sched_result_type   outcome_due[$];
   ssf_entry_type      waiting_requests[$];

   int unsigned req_issued = 0;
   int unsigned req_accepted = 0;
   int unsigned req_gap = 0;
   bit          req_idle_on = 1'b1;
   int unsigned rsp_done = 0;
   int unsigned rsp_done_seen = 0;
   int unsigned rsp_hold = 0;
   bit          rsp_idle_on = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;

   int unsigned n_queued = 0;
   int unsigned n_full = 0;
   int unsigned n_served = 0;
   int unsigned n_empty = 0;
   int unsigned n_ties = 0;
   int unsigned peak_level = 0;

   shortest_seek_first_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic sched_result_type schedule_outcome(disk_item_type item);
      sched_result_type res;
      ssf_entry_type entry;
      int best;
      int best_dist;
      int span;
      res = '{status: STATUS_QUEUED, default: '0};
      if (item.func == FUNC_ADD) begin
         if (waiting_requests.size() >= QUEUE_DEPTH) begin
            res.status = STATUS_FULL;
            n_full++;
         end else begin
            entry.id    = item.id;
            entry.track = item.track;
            waiting_requests.insert(waiting_requests.size(), entry);
            n_queued++;
         end
      end else if (waiting_requests.size() == 0) begin
         res.status = STATUS_EMPTY;
         n_empty++;
      end else begin
         best = 0;
         best_dist = 1 << TRACK_WIDTH;
         foreach (waiting_requests[i]) begin
            span = int'(waiting_requests[i].track) - int'(item.track);
            if (span < 0)
               span = -span;
            if (span == best_dist)
               n_ties++;
            if (span < best_dist) begin
               best_dist = span;
               best = i;
            end
         end
         res.status = STATUS_SERVED;
         res.id     = waiting_requests[best].id;
         res.track  = waiting_requests[best].track;
         res.span   = best_dist[TRACK_WIDTH-1:0];
         waiting_requests.delete(best);
         n_served++;
      end
      res.level = LEVEL_WIDTH'(waiting_requests.size());
      if (waiting_requests.size() > peak_level)
         peak_level = waiting_requests.size();
      return res;
   endfunction

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("[%0t] ERROR %s", $time, msg);
   endtask

   function automatic string show(sched_result_type r);
      return $sformatf("status=%0d id=%02h track=%04h dist=%04h level=%0d",
                       r.status, r.id, r.track, r.span, r.level);
   endfunction

   // accept side and response checker
   always @(posedge clock) begin : monitor
      sched_result_type got;
      sched_result_type want;
      cycle_count++;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            outcome_due.insert(outcome_due.size(), schedule_outcome(on_bus));
            req_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_done++;
            got.status = ssf_status_type'(rsp_tuser);
            got.id     = rsp_tdata[7:0];
            got.track  = rsp_tdata[23:8];
            got.span   = rsp_tdata[39:24];
            got.level  = rsp_tdata[45:40];
            if (outcome_due.size() == 0) begin
               flag_error({"unexpected item: ", show(got)});
            end else begin
               want = outcome_due.pop_front();
               if (got !== want)
                  flag_error({"mismatch: expected ", show(want), " got ", show(got)});
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
                  outcome_due.size());
         $display("shortest_seek_first_scheduler_tb: errors");
         $finish;
      end
   end

   always @(negedge clock) begin : request_driver
      if (!reset) begin
         if (!req_tvalid || req_accepted == req_issued) begin
            if (req_tvalid) begin
               if (req_accepted % 64 == 0)
                  req_idle_on = ($urandom_range(0, 2) != 0);
               req_gap = req_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               on_bus = request_backlog.pop_front();
               req_tdata  <= {on_bus.track, on_bus.id};
               req_tuser  <= on_bus.func;
               req_tvalid <= 1'b1;
               req_issued++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin : response_driver
      if (!reset) begin
         if (rsp_done != rsp_done_seen) begin
            rsp_done_seen = rsp_done;
            if (rsp_done % 64 == 0)
               rsp_idle_on = ($urandom_range(0, 2) != 0);
            rsp_hold = rsp_idle_on ? $urandom_range(0, 9) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic add_item(ssf_func_type func, logic [7:0] id, logic [15:0] track);
      disk_item_type item;
      item.func  = func;
      item.id    = id;
      item.track = track;
      request_backlog.insert(request_backlog.size(), item);
   endtask

   // mode 0 spreads over the disk, 1 clusters near base (ties, duplicates),
   // 2 hugs both ends of the track range
   function automatic logic [15:0] pick_track(int mode, logic [15:0] base);
      case (mode)
         0: return 16'($urandom);
         1: return base + 16'($urandom_range(0, 15));
         default: return $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
                                              : 16'(16'hFFF8 + $urandom_range(0, 7));
      endcase
   endfunction

   initial begin : stimulus
      int made;
      int add_pct;
      int burst;
      int mode;
      logic [15:0] base;
      bit first;

      // directed: empty fetch, extremes, ties with oldest winning both ways
      add_item(FUNC_FETCH, 8'h00, 16'h0000);
      add_item(FUNC_ADD,   8'h00, 16'h0000);
      add_item(FUNC_ADD,   8'hFF, 16'hFFFF);
      add_item(FUNC_ADD,   8'hAA, 16'd100);
      add_item(FUNC_ADD,   8'h55, 16'd200);
      add_item(FUNC_ADD,   8'h01, 16'd100);
      add_item(FUNC_FETCH, 8'hFF, 16'd150);
      add_item(FUNC_FETCH, 8'h00, 16'd100);
      add_item(FUNC_FETCH, 8'h00, 16'hFFFF);
      add_item(FUNC_ADD,   8'h07, 16'hFFFF);
      add_item(FUNC_FETCH, 8'h00, 16'h0000);
      add_item(FUNC_FETCH, 8'h00, 16'h0000);
      add_item(FUNC_FETCH, 8'h00, 16'h0000);
      add_item(FUNC_FETCH, 8'h00, 16'hFFFF);
      add_item(FUNC_ADD,   8'h10, 16'd300);
      add_item(FUNC_ADD,   8'h20, 16'd100);
      add_item(FUNC_FETCH, 8'h00, 16'd200);
      add_item(FUNC_ADD,   8'h5A, 16'h5555);
      add_item(FUNC_ADD,   8'hA5, 16'hAAAA);
      add_item(FUNC_FETCH, 8'h00, 16'h8000);
      add_item(FUNC_FETCH, 8'h00, 16'hFFFF);
      add_item(FUNC_FETCH, 8'h00, 16'h0000);
      add_item(FUNC_FETCH, 8'h00, 16'h1234);

      // random bursts; the first fills the queue past full
      made = 0;
      first = 1'b1;
      while (made < RANDOM_ITEMS) begin
         if (first) begin
            add_pct = 100;
            burst = 36;
            mode = 0;
            first = 1'b0;
         end else begin
            case ($urandom_range(0, 4))
               0: add_pct = 10;
               1: add_pct = 35;
               2: add_pct = 50;
               3: add_pct = 65;
               default: add_pct = 90;
            endcase
            burst = $urandom_range(20, 60);
            mode = $urandom_range(0, 2);
         end
         base = 16'($urandom);
         repeat (burst) begin
            add_item(($urandom_range(1, 100) <= add_pct) ? FUNC_ADD : FUNC_FETCH,
                     8'($urandom), pick_track(mode, base));
            made++;
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_accepted != req_issued ||
             outcome_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outcome_due.size() != 0)
         flag_error($sformatf("%0d expected items never arrived", outcome_due.size()));

      $display("%0d items: %0d queued, %0d dropped on full, %0d served, %0d empty fetches",
               req_accepted, n_queued, n_full, n_served, n_empty);
      $display("peak queue level %0d, %0d equal-distance candidates, %0d errors",
               peak_level, n_ties, error_count);
      if (error_count == 0)
         $display("shortest_seek_first_scheduler_tb: clean");
      else
         $display("shortest_seek_first_scheduler_tb: errors");
      $finish;
   end

endmodule

FILE: shortest_seek_first_scheduler.f
src/ssf_pkg.sv
src/ssf_queue_ram.sv
src/ssf_seek_unit.sv
src/shortest_seek_first_scheduler.sv
test/shortest_seek_first_scheduler_tb.sv
